// File: rtl/core/lcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcr_pkg
// Shared types and constants of the load cell serial reader core.
// ----------------------------------------------------------------------------
package lcr_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PULSES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAM_RATIO     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_REFERENCE = 2'd3;

  localparam int unsigned GAIN_W  = 2;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned RATIO_W = 16;
  localparam int unsigned ZREF_W  = 24;
  localparam int unsigned AVG_W   = 24;
  localparam int unsigned WGT_W   = 25;

  localparam logic [GAIN_W-1:0]  GAIN_RST  = 2'd1;
  localparam logic [COUNT_W-1:0] COUNT_RST = 8'd10;
  localparam logic [RATIO_W-1:0] RATIO_RST = 16'd1;
  localparam logic [ZREF_W-1:0]  ZREF_RST  = 24'd8227020;

  localparam logic [COUNT_W-1:0] MAX_READINGS = 8'd128;
  localparam logic [AVG_W-1:0]   WEIGHT_LIMIT = 24'hFFFFFF;

  typedef struct packed {
    logic meas_clr;
    logic shift_clr;
    logic shift_en;
    logic shift_bit;
    logic pulse_clr;
    logic pulse_inc;
    logic accum;
    logic avg_start;
    logic avg_take;
    logic wgt_start;
    logic commit;
  } lcr_cmd_t;

  typedef struct packed {
    logic bits_last;
    logic pulses_last;
    logic count_last;
    logic div_busy;
  } lcr_sts_t;

endpackage

// File: rtl/core/lcr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcr_ctrl
// Sequencer for the serial read: pin phases, division steps and output stage.
// ----------------------------------------------------------------------------
module lcr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             start_req_i,
  input  logic             data_level_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             sck_level_o,
  output logic             busy_res_o,
  output logic             result_valid_o,
  output lcr_pkg::lcr_cmd_t cmd_o,
  input  lcr_pkg::lcr_sts_t sts_i
);
  import lcr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WAIT,
    S_DATA,
    S_GAIN,
    S_AVG_GO,
    S_AVG,
    S_WGT_GO,
    S_WGT,
    S_DONE
  } state_e;

  state_e   state_q, state_d;
  logic     clk_lvl_q, clk_lvl_d;
  logic     out_valid_q, out_valid_d;
  logic     sck_q, sck_d;
  logic     busy_q, busy_d;
  logic     rv_q, rv_d;
  logic     slot_free;
  logic     tick_ok;
  logic     acc;
  logic     load;
  lcr_cmd_t cmd;

  assign slot_free = !out_valid_q || out_ready_i;
  assign tick_ok   = ((state_q == S_IDLE) || (state_q == S_WAIT) ||
                      (state_q == S_DATA) || (state_q == S_GAIN)) && slot_free;
  assign acc       = in_valid_i && tick_ok;

  always_comb begin
    state_d   = state_q;
    clk_lvl_d = clk_lvl_q;
    cmd       = '0;
    load      = 1'b0;
    cmd.shift_bit = data_level_i;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          load      = 1'b1;
          clk_lvl_d = 1'b0;
          if (start_req_i) begin
            cmd.meas_clr = 1'b1;
            state_d      = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        if (acc) begin
          load      = 1'b1;
          clk_lvl_d = 1'b0;
          if (!data_level_i) begin
            cmd.shift_clr = 1'b1;
            state_d       = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (acc) begin
          load = 1'b1;
          if (!clk_lvl_q) begin
            clk_lvl_d = 1'b1;
          end else begin
            clk_lvl_d    = 1'b0;
            cmd.shift_en = 1'b1;
            if (sts_i.bits_last) begin
              cmd.pulse_clr = 1'b1;
              state_d       = S_GAIN;
            end
          end
        end
      end
      S_GAIN: begin
        if (acc) begin
          if (!clk_lvl_q) begin
            load      = 1'b1;
            clk_lvl_d = 1'b1;
          end else begin
            clk_lvl_d     = 1'b0;
            cmd.pulse_inc = 1'b1;
            if (sts_i.pulses_last) begin
              cmd.accum = 1'b1;
              if (sts_i.count_last) begin
                state_d = S_AVG_GO;
              end else begin
                load    = 1'b1;
                state_d = S_WAIT;
              end
            end else begin
              load = 1'b1;
            end
          end
        end
      end
      S_AVG_GO: begin
        cmd.avg_start = 1'b1;
        state_d       = S_AVG;
      end
      S_AVG: begin
        if (!sts_i.div_busy) begin
          cmd.avg_take = 1'b1;
          state_d      = S_WGT_GO;
        end
      end
      S_WGT_GO: begin
        cmd.wgt_start = 1'b1;
        state_d       = S_WGT;
      end
      S_WGT: begin
        if (!sts_i.div_busy) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          load       = 1'b1;
          cmd.commit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = out_valid_q;
    sck_d       = sck_q;
    busy_d      = busy_q;
    rv_d        = rv_q;
    if (load) begin
      out_valid_d = 1'b1;
      sck_d       = clk_lvl_d;
      busy_d      = (state_d != S_IDLE);
      rv_d        = (state_q == S_DONE);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      clk_lvl_q   <= 1'b0;
      out_valid_q <= 1'b0;
      sck_q       <= 1'b0;
      busy_q      <= 1'b0;
      rv_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      clk_lvl_q   <= clk_lvl_d;
      out_valid_q <= out_valid_d;
      sck_q       <= sck_d;
      busy_q      <= busy_d;
      rv_q        <= rv_d;
    end
  end

  assign in_ready_o     = tick_ok;
  assign out_valid_o    = out_valid_q;
  assign sck_level_o    = sck_q;
  assign busy_res_o     = busy_q;
  assign result_valid_o = rv_q;
  assign cmd_o          = cmd;

endmodule

// File: rtl/core/lcr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcr_datapath
// Configuration registers, shift register, counters, reading sum and a
// shared radix-2 restoring divider for the average and the weight.
// ----------------------------------------------------------------------------
module lcr_datapath #(
  parameter int unsigned DATA_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lcr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lcr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  lcr_pkg::lcr_cmd_t                 cmd_i,
  output lcr_pkg::lcr_sts_t                 sts_o,
  output logic [lcr_pkg::AVG_W-1:0]         average_raw_o,
  output logic signed [lcr_pkg::WGT_W-1:0]  weight_o
);
  import lcr_pkg::*;

  localparam int unsigned BC_W  = $clog2(DATA_BITS + 1);
  localparam int unsigned SUM_W = DATA_BITS + 7;
  localparam int unsigned MAG_W = (DATA_BITS > ZREF_W) ? DATA_BITS : ZREF_W;
  localparam int unsigned NUM_W = MAG_W + 1;
  localparam int unsigned DW    = (SUM_W > NUM_W) ? SUM_W : NUM_W;
  localparam int unsigned DC_W  = $clog2(DW + 1);

  logic [GAIN_W-1:0]    gain_q;
  logic [COUNT_W-1:0]   count_q;
  logic [RATIO_W-1:0]   ratio_q;
  logic [ZREF_W-1:0]    zref_q;

  logic [DATA_BITS-1:0] shift_q;
  logic [BC_W-1:0]      bit_cnt_q;
  logic [GAIN_W-1:0]    pulse_cnt_q;
  logic [COUNT_W-1:0]   rd_cnt_q;
  logic [SUM_W-1:0]     sum_q;
  logic [DATA_BITS-1:0] avg_q;
  logic                 neg_q;
  logic [AVG_W-1:0]     last_avg_q;
  logic [WGT_W-1:0]     last_wgt_q;

  logic [DW-1:0]        quo_q;
  logic [RATIO_W-1:0]   rem_q;
  logic [RATIO_W-1:0]   dvs_q;
  logic [DC_W-1:0]      div_cnt_q;

  logic [GAIN_W-1:0]    gain_eff;
  logic [COUNT_W:0]     count_eff;
  logic [RATIO_W-1:0]   ratio_eff;
  logic [DATA_BITS-1:0] reading;
  logic [MAG_W-1:0]     avg_ext;
  logic [NUM_W-1:0]     num;
  logic [NUM_W-1:0]     num_mag;
  logic [RATIO_W:0]     trial;
  logic                 trial_ge;
  logic [AVG_W-1:0]     wgt_sat;
  logic [WGT_W-1:0]     wgt_abs;
  logic [WGT_W-1:0]     wgt_val;

  always_comb begin
    gain_eff = (gain_q == '0) ? GAIN_W'(1) : gain_q;
    if (count_q == '0) begin
      count_eff = (COUNT_W + 1)'(1);
    end else if (count_q > MAX_READINGS) begin
      count_eff = {1'b0, MAX_READINGS};
    end else begin
      count_eff = {1'b0, count_q};
    end
    ratio_eff = (ratio_q == '0) ? RATIO_W'(1) : ratio_q;
  end

  assign reading = {~shift_q[DATA_BITS-1], shift_q[DATA_BITS-2:0]};
  assign avg_ext = MAG_W'(avg_q);
  assign num     = {1'b0, MAG_W'(zref_q)} - {1'b0, avg_ext};
  assign num_mag = num[NUM_W-1] ? (NUM_W'(0) - num) : num;

  assign trial    = {rem_q, quo_q[DW-1]};
  assign trial_ge = (trial >= {1'b0, dvs_q});

  assign wgt_sat = (|quo_q[DW-1:AVG_W]) ? WEIGHT_LIMIT : quo_q[AVG_W-1:0];
  assign wgt_abs = {1'b0, wgt_sat};
  assign wgt_val = neg_q ? (WGT_W'(0) - wgt_abs) : wgt_abs;

  assign sts_o.bits_last   = (bit_cnt_q == BC_W'(DATA_BITS - 1));
  assign sts_o.pulses_last = (({1'b0, pulse_cnt_q} + 3'd1) >= {1'b0, gain_eff});
  assign sts_o.count_last  = (({1'b0, rd_cnt_q} + (COUNT_W + 1)'(1)) >= count_eff);
  assign sts_o.div_busy    = (div_cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RST;
      count_q <= COUNT_RST;
      ratio_q <= RATIO_RST;
      zref_q <= ZREF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GAIN_PULSES:    gain_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_AVERAGE_COUNT:  count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_GRAM_RATIO:     ratio_q <= cfg_data_i[RATIO_W-1:0];
        CFG_ZERO_REFERENCE: zref_q  <= cfg_data_i[ZREF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= '0;
      bit_cnt_q   <= '0;
      pulse_cnt_q <= '0;
      rd_cnt_q    <= '0;
      sum_q       <= '0;
      div_cnt_q   <= '0;
      last_avg_q  <= '0;
      last_wgt_q  <= '0;
    end else begin
      if (cmd_i.shift_clr) begin
        shift_q   <= '0;
        bit_cnt_q <= '0;
      end else if (cmd_i.shift_en) begin
        shift_q   <= {shift_q[DATA_BITS-2:0], cmd_i.shift_bit};
        bit_cnt_q <= bit_cnt_q + BC_W'(1);
      end
      if (cmd_i.pulse_clr) begin
        pulse_cnt_q <= '0;
      end else if (cmd_i.pulse_inc) begin
        pulse_cnt_q <= pulse_cnt_q + GAIN_W'(1);
      end
      if (cmd_i.meas_clr) begin
        rd_cnt_q <= '0;
        sum_q    <= '0;
      end else if (cmd_i.accum) begin
        rd_cnt_q <= rd_cnt_q + COUNT_W'(1);
        sum_q    <= sum_q + SUM_W'(reading);
      end
      if (cmd_i.avg_start || cmd_i.wgt_start) begin
        div_cnt_q <= DC_W'(DW);
      end else if (div_cnt_q != '0) begin
        div_cnt_q <= div_cnt_q - DC_W'(1);
      end
      if (cmd_i.commit) begin
        last_avg_q <= avg_ext[AVG_W-1:0];
        last_wgt_q <= wgt_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.avg_start) begin
      quo_q <= DW'(sum_q);
      rem_q <= '0;
      dvs_q <= RATIO_W'(rd_cnt_q);
    end else if (cmd_i.wgt_start) begin
      quo_q <= DW'(num_mag);
      rem_q <= '0;
      dvs_q <= ratio_eff;
      neg_q <= num[NUM_W-1];
    end else if (div_cnt_q != '0) begin
      quo_q <= {quo_q[DW-2:0], trial_ge};
      rem_q <= trial_ge ? RATIO_W'(trial - {1'b0, dvs_q}) : trial[RATIO_W-1:0];
    end
    if (cmd_i.avg_take) begin
      avg_q <= quo_q[DATA_BITS-1:0];
    end
  end

  assign average_raw_o = last_avg_q;
  assign weight_o      = $signed(last_wgt_q);

endmodule

// File: rtl/core/load_cell_adc_serial_reader_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_cell_adc_serial_reader_core
// Bridge converter serial reader: averages readings and scales to weight.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  tick in  | in_valid_i/in_ready_o  | start_req_i, data_level_i
//  tick out | out_valid_o/out_ready_i| sck_level_o, busy_res_o,
//           |                        | result_valid_o, average_raw_o, weight_o
//  config   | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// one tick per cycle while no division runs; the tick that ends a measurement
// is answered after the shared one-bit-per-cycle divider, DW = max(DATA_BITS+7, 25)
// bits wide, has run for averaging, then for weight scaling
// reset: idle, registers at their defaults, no result pending
// a stalled output holds its transaction and blocks the next tick
module load_cell_adc_serial_reader_core #(
  parameter int unsigned DATA_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lcr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lcr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              start_req_i,
  input  logic                              data_level_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              sck_level_o,
  output logic                              busy_res_o,
  output logic                              result_valid_o,
  output logic [lcr_pkg::AVG_W-1:0]         average_raw_o,
  output logic signed [lcr_pkg::WGT_W-1:0]  weight_o
);
  import lcr_pkg::*;

  lcr_cmd_t cmd;
  lcr_sts_t sts;

  lcr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .start_req_i    (start_req_i),
    .data_level_i   (data_level_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sck_level_o    (sck_level_o),
    .busy_res_o     (busy_res_o),
    .result_valid_o (result_valid_o),
    .cmd_o          (cmd),
    .sts_i          (sts)
  );

  lcr_datapath #(
    .DATA_BITS (DATA_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .average_raw_o (average_raw_o),
    .weight_o      (weight_o)
  );

endmodule
